// ===== rtl/binary_image_thinning_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binary image thinning block
// Macros that expand to concurrent assertions, or to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_IMAGE_THINNING_DEFINES_SVH
`define BINARY_IMAGE_THINNING_DEFINES_SVH

`ifndef SYNTH
`define BIT_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define BIT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define BIT_ASSERT_SAME(label, clk, rst_n, a, b)
`define BIT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

// ===== rtl/bith_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bith_pkg
// Shared constants, codes and helpers of the binary image thinning block.
// ----------------------------------------------------------------------------
package bith_pkg;

	localparam int MAX_ROWS = 256;
	localparam int MAX_COLS = 256;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int CFG_W    = 9;
	localparam int PASS_W   = 10;
	localparam logic [PASS_W-1:0] PASS_MAX = '1;

	localparam logic [3:0] B_MIN = 4'd2;
	localparam logic [3:0] B_MAX = 4'd6;
	localparam logic [7:0] PIX_ON = 8'd255;

	// Sequencer steps per pixel: nine reads, then the write-back.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_LAST_RD = 4'd8;
	localparam logic [STEP_W-1:0] STEP_WR      = 4'd10;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_RUN  = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// Effective dimension: zero acts as one, oversize acts as the maximum.
	function automatic logic [ROW_W:0] eff_rows(input logic [CFG_W-1:0] v);
		logic [ROW_W:0] res;
		if (v == '0) res = (ROW_W+1)'(1);
		else if (int'(v) > MAX_ROWS) res = (ROW_W+1)'(MAX_ROWS);
		else res = (ROW_W+1)'(v);
		return res;
	endfunction

	function automatic logic [COL_W:0] eff_cols(input logic [CFG_W-1:0] v);
		logic [COL_W:0] res;
		if (v == '0) res = (COL_W+1)'(1);
		else if (int'(v) > MAX_COLS) res = (COL_W+1)'(MAX_COLS);
		else res = (COL_W+1)'(v);
		return res;
	endfunction

endpackage

// ===== rtl/bith_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bith_ram
// One-bit-wide memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bith_ram #(
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/bith_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bith_eval
// Zhang-Suen deletion test on a gathered 3x3 neighborhood.
// ----------------------------------------------------------------------------
module bith_eval (
	input  logic [8:0] nb,     // center, then P2 .. P9
	input  logic       phase,
	output logic       del
);

	logic [7:0] n;
	logic [3:0] b;
	logic [3:0] a;

	always_comb begin
		n = nb[8:1];
		b = 4'($countones(n));
		a = '0;
		for (int k = 0; k < 8; k++) begin
			if (!n[k] && n[(k + 1) % 8]) a = a + 4'd1;
		end
		del = nb[0] && (b >= bith_pkg::B_MIN) && (b <= bith_pkg::B_MAX) && (a == 4'd1);
		if (!phase) begin
			if ((n[0] & n[2] & n[4]) || (n[2] & n[4] & n[6])) del = 1'b0;
		end else begin
			if ((n[0] & n[2] & n[6]) || (n[0] & n[4] & n[6])) del = 1'b0;
		end
	end

endmodule

// ===== rtl/binary_image_thinning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_image_thinning
// Zhang-Suen skeletonization of a binary image held in on-chip memory.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: s_tuser carries the command and s_tdata
// the grayscale pixel. A load request stores one binarized pixel at the raster
// pointer and is taken every cycle unless held off. A read request returns one
// pixel on the m_ channel via a pending flag and the output register, with
// tlast on the final pixel; a pending read holds off new requests. A run
// request thins the image in place and answers with the pass count. Image sizes
// come from the configuration channel, and any register write returns the
// raster pointer to the first pixel. Configuration writes are taken only
// between runs, and a write offered in the same cycle as a request goes first
// while the request waits. Pixels sit at raster address row * cols + col, so a
// size change keeps them. A run walks the image once per sub-iteration with
// one shared neighborhood unit: nine reads and one write per pixel. The image
// ping-pongs between two bit memories, which holds every decision to the image
// as it stood before the sub-iteration.
// Reset clears control state only; image memory contents are undefined until
// loaded. A stalled receiver holds the result in the output register, and new
// requests are refused until it is taken or being taken.
// ----------------------------------------------------------------------------
`include "binary_image_thinning_defines.svh"

module binary_image_thinning (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel_in
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] pixel_out, [17:8] pass_count, rest zero
	output logic        m_tlast,   // last_pixel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int RW = bith_pkg::ROW_W;
	localparam int CW = bith_pkg::COL_W;
	localparam int AW = bith_pkg::ADDR_W;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t                        state_q;
	logic [bith_pkg::CFG_W-1:0]    rows_q, cols_q;
	logic [RW-1:0]                 r_q;
	logic [CW-1:0]                 c_q;
	logic [AW-1:0]                 addr_q;
	logic                          bank_q;
	logic                          pend_q, pend_last_q;
	logic [bith_pkg::STEP_W-1:0]   step_q;
	logic [8:0]                    nb_q;
	logic                          phase_q, chg_q;
	logic [bith_pkg::PASS_W-1:0]   passes_q;
	logic                          m_tvalid_q, m_tlast_q;
	logic [7:0]                    pix_out_q;
	logic [bith_pkg::PASS_W-1:0]   pass_out_q;

	logic [RW:0] er;
	logic [CW:0] ec;
	logic        out_free, s_acc, c_end, r_end, interior, del;
	logic        run_small, run_done, res_set;
	logic [AW-1:0] ecw, row_base, nbr_addr;
	logic [AW-1:0] raddr, waddr;
	logic          we0, we1, wbit, rd0, rd1, rbit;
	bith_pkg::cmd_t cmd;

	assign er    = bith_pkg::eff_rows(rows_q);
	assign ec    = bith_pkg::eff_cols(cols_q);
	assign ecw   = AW'(ec);
	assign c_end = ({1'b0, c_q} == ec - (CW+1)'(1));
	assign r_end = ({1'b0, r_q} == er - (RW+1)'(1));
	assign cmd   = bith_pkg::cmd_t'(s_tuser);

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && !pend_q && out_free && !cfg_valid;
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = (state_q == ST_IDLE);

	// Neighbor addresses for each read step: one row up or down, then one
	// column left or right. Border pixels may wrap, but they are never judged.
	always_comb begin
		row_base = addr_q;
		case (step_q)
			4'd1, 4'd2, 4'd8: row_base = addr_q - ecw;
			4'd4, 4'd5, 4'd6: row_base = addr_q + ecw;
			default: ;
		endcase
		case (step_q)
			4'd2, 4'd3, 4'd4: nbr_addr = row_base + AW'(1);
			4'd6, 4'd7, 4'd8: nbr_addr = row_base - AW'(1);
			default: nbr_addr = row_base;
		endcase
	end

	assign raddr = (state_q == ST_RUN) ? nbr_addr : addr_q;
	assign waddr = addr_q;
	assign interior = (r_q != '0) && !r_end && (c_q != '0) && !c_end;
	assign rbit = bank_q ? rd1 : rd0;

	// A result is produced by a read, by a run on a small image, or by the
	// last write of a pass that removed nothing.
	assign run_small = (er < (RW+1)'(3)) || (ec < (CW+1)'(3));
	assign run_done  = (state_q == ST_RUN) && (step_q == bith_pkg::STEP_WR) &&
		c_end && r_end && phase_q && !(chg_q || (interior && del));
	assign res_set   = pend_q || (s_acc && cmd == bith_pkg::CMD_RUN && run_small) ||
		run_done;

	// Loads write the current bank; a sub-iteration writes the other one.
	always_comb begin
		we0 = 1'b0;
		we1 = 1'b0;
		wbit = 1'b0;
		if (state_q == ST_RUN) begin
			wbit = nb_q[0] && !(interior && del);
			if (step_q == bith_pkg::STEP_WR) begin
				we0 = bank_q;
				we1 = !bank_q;
			end
		end else if (s_acc && cmd == bith_pkg::CMD_LOAD) begin
			wbit = (s_tdata != 8'd0);
			we0 = !bank_q;
			we1 = bank_q;
		end
	end

	bith_ram #(.AW(AW)) u_ram0 (
		.clk(clk), .we(we0), .waddr(waddr), .wdata(wbit), .raddr(raddr), .rdata(rd0)
	);
	bith_ram #(.AW(AW)) u_ram1 (
		.clk(clk), .we(we1), .waddr(waddr), .wdata(wbit), .raddr(raddr), .rdata(rd1)
	);

	bith_eval u_eval (.nb(nb_q), .phase(phase_q), .del(del));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_q      <= 9'd256;
			cols_q      <= 9'd256;
			r_q         <= '0;
			c_q         <= '0;
			addr_q      <= '0;
			bank_q      <= 1'b0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
			step_q      <= '0;
			nb_q        <= '0;
			phase_q     <= 1'b0;
			chg_q       <= 1'b0;
			passes_q    <= '0;
			m_tvalid_q  <= 1'b0;
			m_tlast_q   <= 1'b0;
			pix_out_q   <= '0;
			pass_out_q  <= '0;
		end else begin
			if (res_set) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;

			// A pending read registers the memory output as the result.
			if (pend_q) begin
				pend_q     <= 1'b0;
				pix_out_q  <= rbit ? bith_pkg::PIX_ON : 8'd0;
				pass_out_q <= '0;
				m_tlast_q  <= pend_last_q;
			end

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bith_pkg::REG_ROWS) rows_q <= cfg_data;
				else cols_q <= cfg_data;
				r_q    <= '0;
				c_q    <= '0;
				addr_q <= '0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						case (cmd)
							bith_pkg::CMD_LOAD, bith_pkg::CMD_READ: begin
								if (cmd == bith_pkg::CMD_READ) begin
									pend_q      <= 1'b1;
									pend_last_q <= c_end && r_end;
								end
								if (c_end) begin
									c_q <= '0;
									r_q <= r_end ? '0 : r_q + RW'(1);
								end else begin
									c_q <= c_q + CW'(1);
								end
								addr_q <= (c_end && r_end) ? '0 : addr_q + AW'(1);
							end
							bith_pkg::CMD_RUN: begin
								r_q    <= '0;
								c_q    <= '0;
								addr_q <= '0;
								if (run_small) begin
									pix_out_q  <= '0;
									pass_out_q <= '0;
									m_tlast_q  <= 1'b0;
								end else begin
									state_q  <= ST_RUN;
									step_q   <= '0;
									phase_q  <= 1'b0;
									chg_q    <= 1'b0;
									passes_q <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					if (step_q != '0 && step_q <= bith_pkg::STEP_LAST_RD + 4'd1) begin
						nb_q <= {rbit, nb_q[8:1]};
					end
					if (step_q != bith_pkg::STEP_WR) begin
						step_q <= step_q + 4'd1;
					end else begin
						step_q <= '0;
						if (interior && del) chg_q <= 1'b1;
						if (c_end) begin
							c_q <= '0;
							r_q <= r_end ? '0 : r_q + RW'(1);
						end else begin
							c_q <= c_q + CW'(1);
						end
						addr_q <= (c_end && r_end) ? '0 : addr_q + AW'(1);
						// End of a sub-iteration: the written bank becomes current.
						if (c_end && r_end) begin
							bank_q <= !bank_q;
							if (!phase_q) begin
								phase_q <= 1'b1;
							end else begin
								phase_q <= 1'b0;
								if (passes_q != bith_pkg::PASS_MAX) passes_q <= passes_q + 1'b1;
								if (run_done) begin
									state_q    <= ST_IDLE;
									pix_out_q  <= '0;
									m_tlast_q  <= 1'b0;
									pass_out_q <= (passes_q != bith_pkg::PASS_MAX) ?
										passes_q + 1'b1 : passes_q;
								end else begin
									chg_q <= 1'b0;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {6'd0, pass_out_q, pix_out_q};

	`BIT_ASSERT_SAME(a_busy_not_ready, clk, arst_n, state_q == ST_RUN, !s_tready)
	`BIT_ASSERT_NEXT(a_read_result, clk, arst_n, pend_q, m_tvalid_q)
	`BIT_ASSERT_SAME(a_step_range, clk, arst_n, state_q == ST_RUN, step_q <= bith_pkg::STEP_WR)

endmodule

// ===== tb/sv/binary_image_thinning_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_image_thinning_checker
// Watches the request, result and configuration channels of the thinning
// block, keeps its own bit image, predicts every result and compares.
// ----------------------------------------------------------------------------
module binary_image_thinning_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0]                  pixel;
		logic [bith_pkg::PASS_W-1:0] passes;
		logic                        last;
	} skel_result_t;

	bit           skel_img [bith_pkg::MAX_ROWS*bith_pkg::MAX_COLS];
	bit           kill_mark [bith_pkg::MAX_ROWS*bith_pkg::MAX_COLS];
	logic [8:0]   rows_reg;
	logic [8:0]   cols_reg;
	int unsigned  raster_ptr;
	skel_result_t awaited_results [$];

	function automatic int unsigned clamp_dim(logic [8:0] v, int unsigned lim);
		if (v == 0) return 1;
		if (v > lim) return lim;
		return 32'(v);
	endfunction

	function automatic void enqueue_result(skel_result_t item);
		awaited_results = {awaited_results, item};
	endfunction

	// One Zhang-Suen sub-iteration; returns 1 when any pixel was cleared.
	function automatic bit thin_step(int unsigned nr, int unsigned nc, bit second);
		bit nb [8];
		int unsigned at, cnt, trans;
		bit removed;
		removed = 0;
		for (int unsigned r = 1; r + 1 < nr; r++)
			for (int unsigned c = 1; c + 1 < nc; c++) begin
				at = r * nc + c;
				kill_mark[at] = 0;
				if (skel_img[at]) begin
					nb[0] = skel_img[at-nc];   nb[1] = skel_img[at-nc+1];
					nb[2] = skel_img[at+1];    nb[3] = skel_img[at+nc+1];
					nb[4] = skel_img[at+nc];   nb[5] = skel_img[at+nc-1];
					nb[6] = skel_img[at-1];    nb[7] = skel_img[at-nc-1];
					cnt = 0;
					trans = 0;
					for (int k = 0; k < 8; k++) begin
						cnt += nb[k];
						if (!nb[k] && nb[(k+1)%8]) trans++;
					end
					if (cnt >= 2 && cnt <= 6 && trans == 1) begin
						if (!second)
							kill_mark[at] = !(nb[0] & nb[2] & nb[4]) && !(nb[2] & nb[4] & nb[6]);
						else
							kill_mark[at] = !(nb[0] & nb[2] & nb[6]) && !(nb[0] & nb[4] & nb[6]);
					end
				end
			end
		for (int unsigned r = 1; r + 1 < nr; r++)
			for (int unsigned c = 1; c + 1 < nc; c++) begin
				at = r * nc + c;
				if (kill_mark[at]) begin
					skel_img[at] = 0;
					kill_mark[at] = 0;
					removed = 1;
				end
			end
		return removed;
	endfunction

	function automatic int unsigned thin_image();
		int unsigned nr, nc, passes;
		bit busy;
		nr = clamp_dim(rows_reg, bith_pkg::MAX_ROWS);
		nc = clamp_dim(cols_reg, bith_pkg::MAX_COLS);
		passes = 0;
		if (nr < 3 || nc < 3) return 0;
		busy = 1;
		while (busy) begin
			busy = thin_step(nr, nc, 0);
			busy |= thin_step(nr, nc, 1);
			if (passes < bith_pkg::PASS_MAX) passes++;
		end
		return passes;
	endfunction

	task automatic report(string what, int unsigned got, int unsigned want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int unsigned total, p;
		skel_result_t r;
		if (!arst_n) begin
			rows_reg   = 9'd256;
			cols_reg   = 9'd256;
			raster_ptr = 0;
			awaited_results.delete();
			fail_count = 0;
		end else begin
			// Results first: a result taken at this edge stems from an older request.
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					report("unexpected result tdata", m_tdata, 0);
				end else begin
					r = awaited_results.pop_front();
					if (m_tdata[7:0] != r.pixel) report("pixel_out", m_tdata[7:0], r.pixel);
					if (m_tdata[17:8] != r.passes) report("pass_count", m_tdata[17:8], r.passes);
					if (m_tlast != r.last) report("last_pixel", m_tlast, r.last);
					if (m_tdata[23:18] != 0) report("tdata padding", m_tdata[23:18], 0);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bith_pkg::REG_ROWS) rows_reg = cfg_data;
				else cols_reg = cfg_data;
				raster_ptr = 0;
			end
			if (s_tvalid && s_tready) begin
				total = clamp_dim(rows_reg, bith_pkg::MAX_ROWS) *
					clamp_dim(cols_reg, bith_pkg::MAX_COLS);
				p = (raster_ptr >= total) ? 0 : raster_ptr;
				case (bith_pkg::cmd_t'(s_tuser))
					bith_pkg::CMD_LOAD: begin
						skel_img[p] = (s_tdata != 0);
						raster_ptr = (p + 1 >= total) ? 0 : p + 1;
					end
					bith_pkg::CMD_RUN: begin
						r.pixel  = 0;
						r.passes = bith_pkg::PASS_W'(thin_image());
						r.last   = 0;
						raster_ptr = 0;
						enqueue_result(r);
					end
					bith_pkg::CMD_READ: begin
						r.pixel  = skel_img[p] ? 8'd255 : 8'd0;
						r.passes = 0;
						r.last   = (p + 1 >= total);
						raster_ptr = r.last ? 0 : p + 1;
						enqueue_result(r);
					end
					default: ;
				endcase
			end
		end
		pending = awaited_results.size();
	end

endmodule

// ===== tb/sv/binary_image_thinning_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_image_thinning_test
// Drives load, run, read and no-op requests and image size writes into the
// thinning block under random idling and a long receiver stall; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module binary_image_thinning_test;

	localparam int CYCLE_LIMIT = 4000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = 0;    // [7:0] pixel_in
	logic [1:0]  s_tuser = 0;    // [1:0] cmd
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [23:0] m_tdata;        // [7:0] pixel_out, [17:8] pass_count, rest zero
	logic        m_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = bith_pkg::REG_ROWS;
	logic [8:0]  cfg_data = 0;

	int fail_count;
	int pending;

	// Idling rates in percent, changed as the run goes on.
	int unsigned send_idle_pct = 12;
	int unsigned recv_stall_pct = 72;
	// A single long receiver hold-off, asked for by the stimulus.
	bit hold_request = 0;
	bit hold_done = 0;
	int hold_left = 0;

	int unsigned requests_sent = 0;
	int unsigned rows_now = 256, cols_now = 256;
	// Marks pixels written since reset, so a read never hits an unloaded bit.
	bit loaded [bith_pkg::MAX_ROWS*bith_pkg::MAX_COLS];

	always #2 clk = ~clk;

	binary_image_thinning dut (.*);

	binary_image_thinning_checker u_checker (.*);

	// The receiver stalls at random, and once holds off for a long stretch
	// while the sender keeps offering reads, so the block backs up.
	always @(posedge clk) begin
		if (hold_request && !hold_done && hold_left == 0) begin
			hold_left <= 300;
			hold_done <= 1;
			m_tready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 0;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Guard against a hung block.
	int unsigned cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int unsigned size_of(int unsigned v);
		if (v == 0) return 1;
		if (v > 256) return 256;
		return v;
	endfunction

	// Offer one request and wait until it is accepted. The valid stays high
	// afterwards; the next request either replaces it or lowers it first.
	task automatic send(bith_pkg::cmd_t cmd, logic [7:0] pix);
		int unsigned gap;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(4, 1);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= cmd;
		s_tdata  <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests_sent++;
		if (requests_sent == 550) begin
			send_idle_pct = 72;
			recv_stall_pct = 12;
		end else if (requests_sent == 1100) begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
	endtask

	// Size registers change only once every result is home and the block has
	// had time to finish trailing loads.
	task automatic write_size(logic idx, logic [8:0] value);
		s_tvalid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		if (idx == bith_pkg::REG_ROWS) rows_now = value;
		else cols_now = value;
	endtask

	// Fill the whole image from the first pixel with a given foreground density.
	task automatic load_image(int unsigned density);
		int unsigned total;
		total = size_of(rows_now) * size_of(cols_now);
		for (int unsigned i = 0; i < total; i++) begin
			if ($urandom_range(99) < density)
				send(bith_pkg::CMD_LOAD, 8'($urandom_range(255, 1)));
			else send(bith_pkg::CMD_LOAD, 8'd0);
			loaded[i] = 1;
		end
	endtask

	function automatic bit image_ready();
		int unsigned total;
		total = size_of(rows_now) * size_of(cols_now);
		for (int unsigned i = 0; i < total; i++)
			if (!loaded[i]) return 0;
		return 1;
	endfunction

	function automatic logic [8:0] pick_size();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 6) return 9'd0;
		if (sel < 10) return 9'd256;
		if (sel < 13) return 9'd511;
		if (sel < 15) return 9'($urandom_range(511, 257));
		return 9'($urandom_range(9, 1));
	endfunction

	initial begin
		logic [8:0] nr, nc;
		int unsigned density, mix, sel;
		logic [7:0] edge_pix [4];
		edge_pix = '{8'h00, 8'h01, 8'h80, 8'hFF};

		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: a 3 x 4 image with extreme pixel values, a run, a full
		// read-back that wraps the pointer, and an ignored command.
		write_size(bith_pkg::REG_ROWS, 9'd3);
		write_size(bith_pkg::REG_COLS, 9'd4);
		for (int i = 0; i < 12; i++) begin
			send(bith_pkg::CMD_LOAD, (i == 5 || i == 6) ? 8'h80 : edge_pix[i % 4]);
			loaded[i] = 1;
		end
		send(bith_pkg::CMD_NOP, 8'hFF);
		send(bith_pkg::CMD_RUN, 8'h00);
		for (int i = 0; i < 13; i++) send(bith_pkg::CMD_READ, 8'h00);

		// Random phases: new sizes, a full load where needed, then a mix.
		while (requests_sent < 1650) begin
			nr = pick_size();
			nc = pick_size();
			// Keep large images narrow so that runs stay affordable.
			if (size_of(nr) * size_of(nc) > 768) begin
				if ($urandom_range(1)) nr = 9'd3;
				else nc = 9'd3;
			end
			sel = $urandom_range(9);
			if (sel < 5) begin
				write_size(bith_pkg::REG_ROWS, nr);
				write_size(bith_pkg::REG_COLS, nc);
			end else if (sel < 8) begin
				write_size(bith_pkg::REG_COLS, nc);
				write_size(bith_pkg::REG_ROWS, nr);
			end else if (sel == 8)
				write_size(bith_pkg::REG_ROWS, nr);
			else
				write_size(bith_pkg::REG_COLS, nc);

			density = $urandom_range(90, 25);
			if (!image_ready() || $urandom_range(3) != 0) load_image(density);
			send(bith_pkg::CMD_RUN, 8'($urandom));

			if (requests_sent > 300 && !hold_done) begin
				hold_request = 1;
				for (int i = 0; i < 40; i++) send(bith_pkg::CMD_READ, 8'($urandom));
			end

			mix = $urandom_range(60, 20);
			for (int i = 0; i < mix; i++) begin
				sel = $urandom_range(99);
				if (sel < 45) send(bith_pkg::CMD_LOAD, ($urandom_range(99) < density) ?
					8'($urandom_range(255, 1)) : 8'd0);
				else if (sel < 92) send(bith_pkg::CMD_READ, 8'($urandom));
				else if (sel < 96) send(bith_pkg::CMD_RUN, 8'($urandom));
				else send(bith_pkg::CMD_NOP, 8'($urandom));
			end
		end

		s_tvalid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bith_pkg.sv
rtl/bith_ram.sv
rtl/bith_eval.sv
rtl/binary_image_thinning.sv
tb/sv/binary_image_thinning_checker.sv
tb/sv/binary_image_thinning_test.sv
